// ===== rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, register indexes and constants of the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

	// Width of the CORDIC datapath: Q2.30 values with headroom for growth.
	localparam int CW = 34;
	localparam int MW = 34;
	localparam int PW = 2 * MW;
	localparam int ATAN_N = 32;
	localparam int STEP_W = $clog2(ATAN_N);

	localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

	localparam logic CFG_DISTANCE_GAIN = 1'b0;
	localparam logic CFG_HEADING_GAIN  = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] right_angle;
		logic signed [31:0] left_angle;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [31:0] heading;
	} pose_t;

	typedef struct packed {
		logic        index;
		logic [31:0] value;
	} cfg_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [CW-1:0] cos;
		logic signed [CW-1:0] sin;
	} cordic_res_t;

	// Arctangent of 2^-i as a binary angle, 2^32 per turn.
	function automatic logic [29:0] atan_at(input logic [STEP_W-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'h20000000;
			5'd1:  v = 30'h12E4051E;
			5'd2:  v = 30'h09FB385B;
			5'd3:  v = 30'h051111D4;
			5'd4:  v = 30'h028B0D43;
			5'd5:  v = 30'h0145D7E1;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/ddo_stream_if.sv =====
// ----------------------------------------------------------------------------
// ddo_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface ddo_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ddo_mul.sv =====
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul
	import ddo_pkg::*;
(
	input  logic                 clk,
	input  logic signed [MW-1:0] a,
	input  logic signed [MW-1:0] b,
	output logic signed [PW-1:0] p
);

	logic signed [PW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PW'(a) * PW'(b);
	end

	assign p = p_q;

endmodule

// ===== rtl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic
	import ddo_pkg::*;
#(
	parameter int STEPS = 24
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] angle,
	output cordic_res_t res
);

	logic                 busy_q;
	logic                 done_q;
	logic                 flip_q;
	logic [STEP_W-1:0]    step_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic signed [CW-1:0] xs, ys, at;
	logic [31:0]          folded;

	// Angles in the second and third quadrant are rotated by a half turn,
	// which toggles the top bit, and the results are negated afterwards.
	assign folded = {angle[31] ^ (angle[31] ^ angle[30]), angle[30:0]};
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = CW'(atan_at(step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= angle[31] ^ angle[30];
			x_q    <= CORDIC_K;
			y_q    <= '0;
			z_q    <= CW'($signed(folded));
		end else if (busy_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		res.done = done_q;
		res.cos  = flip_q ? -x_q : x_q;
		res.sin  = flip_q ? -y_q : y_q;
	end

endmodule

// ===== rtl/differential_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Midpoint-heading odometry: wheel deltas, shared multiplier, CORDIC turn.
// ----------------------------------------------------------------------------
// A start request goes from S_IDLE to S_OUT, where the pose is loaded; an update
// passes S_DIST, S_HEAD, S_CHK, then S_CORD, S_MX, S_MY, S_FIN with motion, to
// S_OUT. A new request is taken only in S_IDLE, once the last one is done, and
// the single shared multiplier serves all four products; S_OUT waits on ready.
// Reset clears angles and pose and loads the gain registers with their defaults.
module differential_drive_odometry
	import ddo_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
)(
	input  logic         clk,
	input  logic         arst_n,
	ddo_stream_if.sink   sample,
	ddo_stream_if.source pose,
	ddo_stream_if.sink   cfg
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIST, S_HEAD, S_CHK, S_CORD, S_MX, S_MY, S_FIN, S_OUT
	} state_t;

	state_t      state_q;
	logic [23:0] dist_gain_q;
	logic [31:0] head_gain_q;
	logic [31:0] prev_r_q, prev_l_q;
	logic [31:0] dr_q, dl_q;
	logic [31:0] x_acc_q, y_acc_q, head_acc_q;
	logic [31:0] dist_q, dh_q;
	pose_t       pose_q;
	logic        pose_valid_q;

	logic signed [32:0]   dsum, ddiff;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [57:0]   dist_rnd;
	logic [31:0]          dist_c;
	logic [40:0]          r128, r256;
	logic [31:0]          dh_c, half_c;
	logic signed [PW-1:0] pos_rnd;
	logic [31:0]          acc_sel;
	logic signed [38:0]   pos_sum;
	logic [31:0]          pos_c;
	logic                 motion;
	logic                 cordic_start;
	logic                 pose_load;
	cordic_res_t          cres;
	sample_t              smp;
	cfg_req_t             creq;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	assign smp  = sample.data;
	assign creq = cfg.data;

	assign sample.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign pose.valid   = pose_valid_q;
	assign pose.data    = pose_q;

	assign dsum  = 33'($signed(dr_q)) + 33'($signed(dl_q));
	assign ddiff = 33'($signed(dr_q)) - 33'($signed(dl_q));

	always_comb begin
		case (state_q)
			S_DIST: begin
				mul_a = MW'(dsum);
				mul_b = MW'($signed({1'b0, dist_gain_q}));
			end
			S_HEAD: begin
				mul_a = MW'(ddiff);
				mul_b = MW'($signed({1'b0, head_gain_q}));
			end
			S_MX: begin
				mul_a = MW'($signed(dist_q));
				mul_b = cres.cos;
			end
			S_MY: begin
				mul_a = MW'($signed(dist_q));
				mul_b = cres.sin;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ddo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Distance rounds half up after halving the summed wheel travel.
	assign dist_rnd = $signed(mul_p[57:0]) + 58'sd1;
	assign dist_c   = sat32(64'(dist_rnd >>> 1));

	// Only the low bits of the wrapped heading product reach the results.
	assign r128   = mul_p[40:0] + 41'd128;
	assign r256   = mul_p[40:0] + 41'd256;
	assign dh_c   = r128[39:8];
	assign half_c = r256[40:9];
	assign motion = (dist_q != 32'd0) || (dh_c != 32'd0);

	assign cordic_start = (state_q == S_CHK) && motion;

	ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (head_acc_q + half_c),
		.res    (cres)
	);

	// One accumulate-and-saturate path serves x, then y.
	assign pos_rnd = mul_p + PW'(64'sd536870912);
	assign acc_sel = (state_q == S_FIN) ? y_acc_q : x_acc_q;
	assign pos_sum = 39'($signed(acc_sel)) + 39'($signed(pos_rnd[PW-1:30]));
	assign pos_c   = sat32(64'(pos_sum));

	assign pose_load = (state_q == S_OUT) && (!pose_valid_q || pose.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_gain_q <= 24'd32000;
			head_gain_q <= 32'd760000000;
		end else if (cfg.valid) begin
			case (creq.index)
				CFG_DISTANCE_GAIN: dist_gain_q <= creq.value[23:0];
				CFG_HEADING_GAIN:  head_gain_q <= creq.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_r_q     <= '0;
			prev_l_q     <= '0;
			dr_q         <= '0;
			dl_q         <= '0;
			dist_q       <= '0;
			dh_q         <= '0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
			head_acc_q   <= '0;
			pose_q       <= '0;
			pose_valid_q <= 1'b0;
		end else begin
			if (pose_load)
				pose_valid_q <= 1'b1;
			else if (pose.ready)
				pose_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						dr_q     <= smp.right_angle - prev_r_q;
						dl_q     <= smp.left_angle - prev_l_q;
						prev_r_q <= smp.right_angle;
						prev_l_q <= smp.left_angle;
						if (!smp.mode) begin
							x_acc_q    <= '0;
							y_acc_q    <= '0;
							head_acc_q <= '0;
							state_q    <= S_OUT;
						end else begin
							state_q <= S_DIST;
						end
					end
				end
				S_DIST: state_q <= S_HEAD;
				S_HEAD: begin
					dist_q  <= dist_c;
					state_q <= S_CHK;
				end
				S_CHK: begin
					dh_q    <= dh_c;
					state_q <= motion ? S_CORD : S_OUT;
				end
				S_CORD: begin
					if (cres.done)
						state_q <= S_MX;
				end
				S_MX: state_q <= S_MY;
				S_MY: begin
					x_acc_q <= pos_c;
					state_q <= S_FIN;
				end
				S_FIN: begin
					y_acc_q    <= pos_c;
					head_acc_q <= head_acc_q + dh_q;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (pose_load) begin
						pose_q.pos_x   <= x_acc_q;
						pose_q.pos_y   <= y_acc_q;
						pose_q.heading <= head_acc_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
